// ===== sv/mks_pkg.sv =====
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, key codes and the key map for the 4x3 keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    // scan phases: three scanning columns, then debounce, hash hold, release wait
    typedef enum logic [2:0] {
        PH_SCAN0    = 3'd0,
        PH_SCAN1    = 3'd1,
        PH_SCAN2    = 3'd2,
        PH_DEBOUNCE = 3'd3,
        PH_HASH     = 3'd4,
        PH_RELEASE  = 3'd5
    } t_phase;

    localparam logic [3:0] HASH_CODE  = 4'd11;
    localparam logic [3:0] MULTI_CODE = 4'd15;
    localparam logic [1:0] COL_LAST   = 2'd2;
    localparam logic [1:0] COL_NONE   = 2'd3;

    localparam int CFG_DEBOUNCE = 0;
    localparam int CFG_LONG     = 1;

    // key map by row * 3 + column
    localparam logic [3:0] KEY_MAP [12] = '{
        4'd1,  4'd2, 4'd3,
        4'd4,  4'd5, 4'd6,
        4'd7,  4'd8, 4'd9,
        4'd10, 4'd0, 4'd11
    };

    // scan state carried between beats
    typedef struct packed {
        t_phase     phase;
        logic [1:0] col;
    } t_scan;

    // one result beat
    typedef struct packed {
        logic [2:0] column_drive;
        logic       key_valid;
        logic [3:0] key_code;
        logic       hash_short;
        logic       hash_long;
    } t_result;

    // decode a row pattern and the held column into a key code
    function automatic logic [3:0] decode_key(input logic [3:0] rows, input logic [1:0] col);
        logic [1:0] row;
        logic       single;
        logic [3:0] idx;
        row    = 2'd0;
        single = 1'b1;
        case (rows)
            4'b0001: row = 2'd0;
            4'b0010: row = 2'd1;
            4'b0100: row = 2'd2;
            4'b1000: row = 2'd3;
            default: single = 1'b0;
        endcase
        idx = ({2'b00, row} << 1) + {2'b00, row} + {2'b00, col};
        if (!single || col == COL_NONE) begin
            return MULTI_CODE;
        end
        return KEY_MAP[idx];
    endfunction

endpackage

// ===== sv/matrix_keypad_scanner.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 4x3 matrix keypad scanner with debounce and hash-key long-press detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one row sample and a tick
//   flag per beat. Output channel (o_out_valid / i_out_stall) returns one
//   result beat per input beat: the driven column and key/hash pulses.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
//   debounce threshold (index 0) and long-press threshold (index 1); write
//   them only while no beat is in flight.
//   Path: an accepted beat is held in the input register, then the scan
//   step runs into the output register once the output is free, where the
//   result can be taken.
//   Throughput: one beat per cycle while the output is not stalled; the scan
//   step is a combinational update of the phase, column and tick counter.
//   Stall: a stalled output holds its result; the input register still fills
//   once, after which o_in_stall follows i_out_stall.
//   Reset: phase scanning, column 0, counter clear, thresholds 20 and 3000.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner #(
    parameter int TICK_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_row_sense,
    input  logic        i_tick,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_column_drive,
    output logic        o_key_valid,
    output logic [3:0]  o_key_code,
    output logic        o_hash_short,
    output logic        o_hash_long,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mks_pkg::*;

    logic                 r_in_valid;
    logic [3:0]           r_rows;
    logic                 r_tick;
    logic                 r_out_valid;
    t_result              r_result;
    t_scan                r_scan;
    t_scan                n_scan;
    logic [TICK_BITS-1:0] r_count;
    logic [TICK_BITS-1:0] n_count;
    t_result              n_result;
    logic [15:0]          r_debounce_ticks;
    logic [15:0]          r_long_press_ticks;
    logic                 out_free;
    logic                 in_free;
    logic                 step_go;

    // pipeline flow
    assign out_free    = !r_out_valid || !i_out_stall;
    assign step_go     = r_in_valid && out_free;
    assign in_free     = !r_in_valid || out_free;
    assign o_in_stall  = !in_free;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= 16'd20;
            r_long_press_ticks <= 16'd3000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == 2'(CFG_DEBOUNCE)) begin
                r_debounce_ticks <= i_cfg_data;
            end else if (i_cfg_index == 2'(CFG_LONG)) begin
                r_long_press_ticks <= i_cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_rows <= i_row_sense;
            r_tick <= i_tick;
        end
    end

    // scan step
    mks_step #(
        .TICK_BITS (TICK_BITS)
    ) u_step (
        .i_scan             (r_scan),
        .i_count            (r_count),
        .i_rows             (r_rows),
        .i_tick             (r_tick),
        .i_debounce_ticks   (r_debounce_ticks),
        .i_long_press_ticks (r_long_press_ticks),
        .o_scan             (n_scan),
        .o_count            (n_count),
        .o_result           (n_result)
    );

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.phase <= PH_SCAN0;
            r_scan.col   <= 2'd0;
            r_count      <= '0;
        end else if (step_go) begin
            r_scan  <= n_scan;
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_column_drive = r_result.column_drive;
    assign o_key_valid    = r_result.key_valid;
    assign o_key_code     = r_result.key_code;
    assign o_hash_short   = r_result.hash_short;
    assign o_hash_long    = r_result.hash_long;

endmodule

// ===== sv/mks_step.sv =====
// ----------------------------------------------------------------------------
// mks_step
// One scan step: tick counting, phase transitions and result decode.
// ----------------------------------------------------------------------------
module mks_step #(
    parameter int TICK_BITS = 16
) (
    input  mks_pkg::t_scan          i_scan,
    input  logic [TICK_BITS-1:0]    i_count,
    input  logic [3:0]              i_rows,
    input  logic                    i_tick,
    input  logic [15:0]             i_debounce_ticks,
    input  logic [15:0]             i_long_press_ticks,
    output mks_pkg::t_scan          o_scan,
    output logic [TICK_BITS-1:0]    o_count,
    output mks_pkg::t_result        o_result
);
    import mks_pkg::*;

    localparam int CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;

    logic [TICK_BITS-1:0] count_ticked;
    logic [CMP_W-1:0]     count_ext;
    logic                 over_debounce;
    logic                 over_long;
    logic                 rows_idle;
    logic [3:0]           code_now;

    // saturating tick counter, then threshold compares
    assign count_ticked  = (i_tick && !(&i_count)) ? i_count + 1'b1 : i_count;
    assign count_ext     = CMP_W'(count_ticked);
    assign over_debounce = count_ext > CMP_W'(i_debounce_ticks);
    assign over_long     = count_ext > CMP_W'(i_long_press_ticks);
    assign rows_idle     = (i_rows == 4'd0);
    assign code_now      = decode_key(i_rows, i_scan.col);

    // next state
    always_comb begin
        o_scan  = i_scan;
        o_count = count_ticked;
        case (i_scan.phase)
            PH_DEBOUNCE: begin
                if (rows_idle) begin
                    o_scan.col   = COL_LAST;
                    o_scan.phase = PH_SCAN0;
                end else if (over_debounce) begin
                    if (code_now != HASH_CODE) begin
                        o_scan.phase = PH_RELEASE;
                    end else begin
                        o_count      = '0;
                        o_scan.phase = PH_HASH;
                    end
                end
            end
            PH_HASH: begin
                if (rows_idle) begin
                    o_scan.phase = PH_SCAN0;
                end else if (over_long) begin
                    o_scan.phase = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (rows_idle) begin
                    o_scan.col   = COL_LAST;
                    o_scan.phase = PH_SCAN0;
                end
            end
            PH_SCAN1: begin
                if (!rows_idle) begin
                    o_count      = '0;
                    o_scan.phase = PH_DEBOUNCE;
                end else begin
                    o_scan.col   = 2'd1;
                    o_scan.phase = PH_SCAN2;
                end
            end
            PH_SCAN2: begin
                if (!rows_idle) begin
                    o_count      = '0;
                    o_scan.phase = PH_DEBOUNCE;
                end else begin
                    o_scan.col   = 2'd2;
                    o_scan.phase = PH_SCAN0;
                end
            end
            default: begin
                // scan column 0; unused codes behave the same
                if (!rows_idle) begin
                    o_count      = '0;
                    o_scan.phase = PH_DEBOUNCE;
                end else begin
                    o_scan.col   = 2'd0;
                    o_scan.phase = PH_SCAN1;
                end
            end
        endcase
    end

    // result fields
    always_comb begin
        o_result            = '0;
        o_result.column_drive = (o_scan.col == COL_NONE) ? 3'd0 : 3'(3'd1 << o_scan.col);
        case (i_scan.phase)
            PH_DEBOUNCE: begin
                if (!rows_idle && over_debounce && code_now != HASH_CODE) begin
                    o_result.key_valid = 1'b1;
                    o_result.key_code  = code_now;
                end
            end
            PH_HASH: begin
                if (rows_idle) begin
                    o_result.hash_short = 1'b1;
                    o_result.key_code   = HASH_CODE;
                end else if (over_long) begin
                    o_result.hash_long = 1'b1;
                    o_result.key_code  = HASH_CODE;
                end
            end
            default: begin
                o_result.key_valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== sim/matrix_keypad_scanner_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_checker
// Watches the row, result and register channels of the keypad scanner. It
// keeps its own model of the scan phase, held column and tick counter, queues
// one predicted result per accepted row beat and compares every accepted
// result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_checker #(
    parameter int TICK_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // row beats
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_row_sense,
    input  logic        i_tick,
    // result beats
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_column_drive,
    input  logic        i_key_valid,
    input  logic [3:0]  i_key_code,
    input  logic        i_hash_short,
    input  logic        i_hash_long,
    // register writes
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // status for the stimulus side
    output int          o_fail_count,
    output int          o_pending
);
    import mks_pkg::*;

    // model state
    t_phase                 m_phase;
    logic [1:0]             m_col;
    logic [TICK_BITS-1:0]   m_hold;
    logic [15:0]            m_debounce;
    logic [15:0]            m_long;

    t_result scan_predictions [$];
    int      result_idx;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_idx   = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want) begin
            flag_mismatch($sformatf("result %0d %s got %0d want %0d",
                                    result_idx, field, got, want));
        end
    endtask

    // key code for one row pattern and column, 15 for no row or several rows
    function automatic logic [3:0] pad_code(input logic [3:0] rows, input logic [1:0] col);
        int r;
        r = 0;
        case (rows)
            4'b0001: r = 0;
            4'b0010: r = 1;
            4'b0100: r = 2;
            4'b1000: r = 3;
            default: return MULTI_CODE;
        endcase
        if (col == COL_NONE) begin
            return MULTI_CODE;
        end
        if (r < 3) begin
            return 4'(r * 3 + col + 1);
        end
        // bottom row: star, zero, hash
        case (col)
            2'd0:    return 4'd10;
            2'd1:    return 4'd0;
            default: return HASH_CODE;
        endcase
    endfunction

    // one scan step of the model
    task automatic advance_scanner(input logic [3:0] rows, input logic tk,
                                   output t_result res);
        logic [3:0] code_now;
        res = '0;
        if (tk && m_hold != '1) begin
            m_hold = m_hold + 1'b1;
        end
        case (m_phase)
            PH_DEBOUNCE: begin
                code_now = pad_code(rows, m_col);
                if (rows == 4'd0) begin
                    m_col   = COL_LAST;
                    m_phase = PH_SCAN0;
                end else if (m_hold > m_debounce) begin
                    if (code_now != HASH_CODE) begin
                        res.key_valid = 1'b1;
                        res.key_code  = code_now;
                        m_phase       = PH_RELEASE;
                    end else begin
                        m_hold  = '0;
                        m_phase = PH_HASH;
                    end
                end
            end
            PH_HASH: begin
                if (rows == 4'd0) begin
                    res.hash_short = 1'b1;
                    res.key_code   = HASH_CODE;
                    m_phase        = PH_SCAN0;
                end else if (m_hold > m_long) begin
                    res.hash_long = 1'b1;
                    res.key_code  = HASH_CODE;
                    m_phase       = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (rows == 4'd0) begin
                    m_col   = COL_LAST;
                    m_phase = PH_SCAN0;
                end
            end
            default: begin
                if (rows != 4'd0) begin
                    m_hold  = '0;
                    m_phase = PH_DEBOUNCE;
                end else begin
                    // rotate the driven column
                    case (m_phase)
                        PH_SCAN1: begin
                            m_col   = 2'd1;
                            m_phase = PH_SCAN2;
                        end
                        PH_SCAN2: begin
                            m_col   = COL_LAST;
                            m_phase = PH_SCAN0;
                        end
                        default: begin
                            m_col   = 2'd0;
                            m_phase = PH_SCAN1;
                        end
                    endcase
                end
            end
        endcase
        res.column_drive = (m_col == COL_NONE) ? 3'b000 : (3'b001 << m_col);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            m_phase    = PH_SCAN0;
            m_col      = 2'd0;
            m_hold     = '0;
            m_debounce = 16'd20;
            m_long     = 16'd3000;
            scan_predictions.delete();
        end else begin
            // register write beat
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DEBOUNCE) begin
                    m_debounce = i_cfg_data;
                end else if (i_cfg_index == CFG_LONG) begin
                    m_long = i_cfg_data;
                end
            end
            // result beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (scan_predictions.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing predicted",
                                            result_idx));
                end else begin
                    want = scan_predictions.pop_front();
                    check_field("column_drive", i_column_drive, want.column_drive);
                    check_field("key_valid", i_key_valid, want.key_valid);
                    check_field("key_code", i_key_code, want.key_code);
                    check_field("hash_short", i_hash_short, want.hash_short);
                    check_field("hash_long", i_hash_long, want.hash_long);
                end
                result_idx = result_idx + 1;
            end
            // row beat
            if (i_in_valid && !i_in_stall) begin
                advance_scanner(i_row_sense, i_tick, fresh);
                scan_predictions.push_back(fresh);
            end
        end
        o_pending <= scan_predictions.size();
    end

endmodule

// ===== sim/matrix_keypad_scanner_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_tb
// Drives row samples and ticks into the keypad scanner under three stall
// profiles and a range of debounce and long-press thresholds, from a short
// directed sequence of presses through random key, hash and noise bursts to a
// long hash hold. The checker beside the block does the prediction and
// comparison.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_tb;
    import mks_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [3:0]  i_row_sense = 4'd0;
    logic        i_tick      = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data  = 16'd0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_column_drive;
    logic        o_key_valid;
    logic [3:0]  o_key_code;
    logic        o_hash_short;
    logic        o_hash_long;
    logic        o_cfg_ready;

    int fail_count;
    int pending;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int beats_sent         = 0;
    int settings_used      = 0;
    int cur_debounce       = 20;
    int cur_long           = 3000;
    int trail              = 1;

    matrix_keypad_scanner #(
        .TICK_BITS (16)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_row_sense    (i_row_sense),
        .i_tick         (i_tick),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column_drive (o_column_drive),
        .o_key_valid    (o_key_valid),
        .o_key_code     (o_key_code),
        .o_hash_short   (o_hash_short),
        .o_hash_long    (o_hash_long),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    matrix_keypad_scanner_checker #(
        .TICK_BITS (16)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_row_sense    (i_row_sense),
        .i_tick         (i_tick),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_column_drive (o_column_drive),
        .i_key_valid    (o_key_valid),
        .i_key_code     (o_key_code),
        .i_hash_short   (o_hash_short),
        .i_hash_long    (o_hash_long),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // one row beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [3:0] rows, input logic tk);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_row_sense <= 4'($urandom_range(0, 15));
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_row_sense <= rows;
        i_tick      <= tk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent = beats_sent + 1;
    endtask

    task automatic repeat_beat(input logic [3:0] rows, input logic tk, input int n);
        repeat (n) send_beat(rows, tk);
    endtask

    // stop sending and wait until every predicted result is out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input int deb, input int lng);
        drain_results();
        write_reg(2'(CFG_DEBOUNCE), 16'(deb));
        write_reg(2'(CFG_LONG), 16'(lng));
        cur_debounce  = deb;
        cur_long      = lng;
        settings_used = settings_used + 1;
    endtask

    // a press with random hold, occasional bounce, then release
    task automatic key_press_burst(input bit aim_hash);
        logic [3:0] rows;
        int         lead;
        int         span;
        int         hold_len;
        if (aim_hash) begin
            // land on column 2 counting from the last release
            lead = (4 - trail) % 3;
            rows = 4'b1000;
        end else begin
            lead = $urandom_range(0, 4);
            if ($urandom_range(0, 99) < 85) begin
                rows = 4'b0001 << $urandom_range(0, 3);
            end else begin
                rows = 4'($urandom_range(1, 15));
            end
        end
        repeat (lead) send_beat(4'd0, 1'($urandom_range(0, 1)));
        span = cur_debounce + cur_long + 6;
        if (span > 60) span = 60;
        hold_len = $urandom_range(1, span);
        for (int k = 0; k < hold_len; k++) begin
            if (k > 0 && $urandom_range(0, 99) < 6) begin
                send_beat(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end else begin
                send_beat(rows, $urandom_range(0, 99) < 80);
            end
        end
        trail = $urandom_range(1, 3);
        repeat (trail) send_beat(4'd0, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            repeat ($urandom_range(3, 12)) begin
                send_beat(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end
        end else begin
            key_press_burst(pick < 40);
        end
    endtask

    // run limit
    initial begin
        #20_000_000;
        $display("timeout: scanner stopped making progress");
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int goal;
        int deb;
        int lng;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct    = 36;
        receiver_stall_pct = 87;

        // directed presses with short thresholds
        set_thresholds(1, 2);
        // several rows from reset column: code 15
        repeat_beat(4'b1111, 1'b1, 3);
        send_beat(4'd0, 1'b0);
        // hash on column 2, released early: short press
        repeat_beat(4'b1000, 1'b1, 4);
        send_beat(4'd0, 1'b0);
        // hash held past the long threshold, then release wait
        repeat_beat(4'b1000, 1'b1, 6);
        send_beat(4'b1000, 1'b0);
        send_beat(4'd0, 1'b1);
        // top row, column 0
        send_beat(4'd0, 1'b0);
        repeat_beat(4'b0001, 1'b1, 3);
        send_beat(4'd0, 1'b0);
        // bottom row, column 1: code 0
        send_beat(4'd0, 1'b0);
        send_beat(4'd0, 1'b1);
        repeat_beat(4'b1000, 1'b1, 3);
        send_beat(4'd0, 1'b1);

        // random bursts under three stall profiles
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    sender_idle_pct    = 36;
                    receiver_stall_pct = 87;
                end
                1: begin
                    sender_idle_pct    = 87;
                    receiver_stall_pct = 36;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                case (k)
                    0: begin
                        deb = $urandom_range(0, 3);
                        lng = $urandom_range(0, 6);
                    end
                    1: begin
                        deb = (p == 2) ? 65535 : 0;
                        lng = (p == 1) ? 65535 : 0;
                    end
                    2: begin
                        deb = $urandom_range(4, 12);
                        lng = $urandom_range(8, 30);
                    end
                    default: begin
                        deb = (p == 1) ? 1 : 20;
                        lng = (p == 2) ? 3000 : $urandom_range(20, 50);
                    end
                endcase
                set_thresholds(deb, lng);
                goal = beats_sent + 80;
                while (beats_sent < goal) random_burst();
            end
        end

        // hash held well past the long threshold, then released
        set_thresholds(0, 90);
        repeat_beat(4'b0001, 1'b1, 2);
        send_beat(4'd0, 1'b0);
        repeat_beat(4'b1000, 1'b1, 120);
        send_beat(4'd0, 1'b0);
        send_beat(4'd0, 1'b1);

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("covered %0d row beats over %0d threshold settings and three stall profiles,",
                 beats_sent, settings_used);
        $display("with key, multi-row, short and long hash presses and a long hash hold");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
